@@ sv/cct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cct_pkg
// types, codes, constants and sprite patterns of the cursor compositor
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int COORD_W = 12;
  localparam int COLOUR_W = 32;
  localparam int STEP_W = 14;

  localparam int SPRITE_WIDTH_DEF = 10;
  localparam int SPRITE_HEIGHT_DEF = 17;

  // built-in pattern size
  localparam int PAT_W = 10;
  localparam int PAT_H = 17;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [COLOUR_W-1:0] COL_BORDER = 32'h0000_0000;
  localparam logic [COLOUR_W-1:0] COL_FILL = 32'h0000_FFFF;

  localparam logic OP_MOTION = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [2:0] BUTTON_LEFT_ONLY = 3'd1;

  localparam logic [COORD_W-1:0] POS_X_RST = 12'd512;
  localparam logic [COORD_W-1:0] POS_Y_RST = 12'd384;

  typedef enum logic [2:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_HIT_X_LEFT    = 3'd2,
    CFG_HIT_X_RIGHT   = 3'd3,
    CFG_START_Y_TOP   = 3'd4,
    CFG_LIST_Y_TOP    = 3'd5,
    CFG_QUIT_Y_TOP    = 3'd6,
    CFG_REGION_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_NONE  = 2'd0,
    REGION_START = 2'd1,
    REGION_LIST  = 2'd2,
    REGION_QUIT  = 2'd3
  } region_t;

  typedef enum logic {
    CMD_MOVE  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    CELL_CLEAR  = 2'd0,
    CELL_BORDER = 2'd1,
    CELL_FILL   = 2'd2
  } cell_t;

  typedef struct packed {
    logic               op;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy_raw;
    logic [2:0]         button;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [COLOUR_W-1:0] background;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [1:0]         region;
    logic               hover_shape;
    logic               click;
    logic [COLOUR_W-1:0] pixel_out;
  } result_t;

  // classified request between front and back
  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic                     left_only;
    logic [COORD_W-1:0]       pix_x;
    logic [COORD_W-1:0]       pix_y;
    logic [COLOUR_W-1:0]      background;
  } cmd_t;

  // limits derived from the configuration registers
  typedef struct packed {
    logic signed [STEP_W-1:0] x_hi;
    logic signed [STEP_W-1:0] y_hi;
    logic [COORD_W-1:0]       x_left;
    logic [COORD_W-1:0]       x_right;
    logic [COORD_W-1:0]       start_top;
    logic [COORD_W:0]         start_bot;
    logic [COORD_W-1:0]       list_top;
    logic [COORD_W:0]         list_bot;
    logic [COORD_W-1:0]       quit_top;
    logic [COORD_W:0]         quit_bot;
  } lim_t;

  // pattern rows, leftmost column in the msb
  function automatic cell_t sprite_cell(input logic hover, input logic [4:0] row,
                                        input logic [3:0] col);
    logic [PAT_W-1:0] opaque;
    logic [PAT_W-1:0] fill;
    logic [3:0]       bit_idx;
    opaque = '0;
    fill = '0;
    bit_idx = 4'(PAT_W - 1) - col;
    if (hover) begin
      case (row)
        5'd0, 5'd16: begin
          opaque = 10'b1111111111; fill = 10'b0000000000;
        end
        5'd1, 5'd2, 5'd3, 5'd12, 5'd13, 5'd14, 5'd15: begin
          opaque = 10'b1111111111; fill = 10'b0111111110;
        end
        5'd4, 5'd11: begin
          opaque = 10'b0111111110; fill = 10'b0011111100;
        end
        5'd5, 5'd10: begin
          opaque = 10'b0011111100; fill = 10'b0001111000;
        end
        5'd6, 5'd7, 5'd8, 5'd9: begin
          opaque = 10'b0001111000; fill = 10'b0000110000;
        end
        default: begin
          opaque = '0; fill = '0;
        end
      endcase
    end else begin
      case (row)
        5'd0:  begin opaque = 10'b1000000000; fill = 10'b0000000000; end
        5'd1:  begin opaque = 10'b1100000000; fill = 10'b0000000000; end
        5'd2:  begin opaque = 10'b1110000000; fill = 10'b0100000000; end
        5'd3:  begin opaque = 10'b1111000000; fill = 10'b0110000000; end
        5'd4:  begin opaque = 10'b1111100000; fill = 10'b0111000000; end
        5'd5:  begin opaque = 10'b1111110000; fill = 10'b0111100000; end
        5'd6:  begin opaque = 10'b1111111000; fill = 10'b0111110000; end
        5'd7:  begin opaque = 10'b1111111100; fill = 10'b0111111000; end
        5'd8:  begin opaque = 10'b1111111110; fill = 10'b0111111100; end
        5'd9:  begin opaque = 10'b1111111111; fill = 10'b0111111110; end
        5'd10: begin opaque = 10'b1111111111; fill = 10'b0111110000; end
        5'd11: begin opaque = 10'b1111111000; fill = 10'b0110110000; end
        5'd12: begin opaque = 10'b1110111100; fill = 10'b0100011000; end
        5'd13: begin opaque = 10'b1100111100; fill = 10'b0000011000; end
        5'd14, 5'd15: begin
          opaque = 10'b0000011110; fill = 10'b0000001100;
        end
        5'd16: begin opaque = 10'b0000001100; fill = 10'b0000000000; end
        default: begin
          opaque = '0; fill = '0;
        end
      endcase
    end
    if (col >= 4'(PAT_W) || !opaque[bit_idx]) begin
      return CELL_CLEAR;
    end else if (fill[bit_idx]) begin
      return CELL_FILL;
    end else begin
      return CELL_BORDER;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/cct_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cct_fifo
// small register queue with first-word fall-through read
// ----------------------------------------------------------------------------
module cct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/cct_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cct_front
// input stage: takes items and turns them into motion or pixel requests
// ----------------------------------------------------------------------------
module cct_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cct_pkg::item_t item,
  output logic                full,
  output logic                cmd_wr,
  output cct_pkg::cmd_t       cmd,
  input  wire logic           cmd_full
);

  logic          valid;
  logic          take;
  cct_pkg::cmd_t cmd_next;

  assign full = valid && cmd_full;
  assign take = push && !full;
  assign cmd_wr = valid && !cmd_full;

  always_comb begin
    cmd_next.kind = (item.op == cct_pkg::OP_PIXEL) ? cct_pkg::CMD_PIXEL : cct_pkg::CMD_MOVE;
    cmd_next.step_x = {{(cct_pkg::STEP_W - 8){item.dx[7]}}, item.dx};
    // screen y grows downwards, raw dy grows upwards
    cmd_next.step_y = '0 - {{(cct_pkg::STEP_W - 8){item.dy_raw[7]}}, item.dy_raw};
    cmd_next.left_only = (item.button == cct_pkg::BUTTON_LEFT_ONLY);
    cmd_next.pix_x = item.pix_x;
    cmd_next.pix_y = item.pix_y;
    cmd_next.background = item.background;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (cmd_wr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/cct_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cct_back
// execution stage: keeps the cursor, tests regions and composites pixels
// ----------------------------------------------------------------------------
module cct_back #(
  parameter int SPRITE_WIDTH = cct_pkg::SPRITE_WIDTH_DEF,
  parameter int SPRITE_HEIGHT = cct_pkg::SPRITE_HEIGHT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cct_pkg::lim_t  lim,
  input  wire cct_pkg::cmd_t  cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_rd,
  output logic                res_wr,
  output cct_pkg::result_t    res,
  input  wire logic           res_full
);

  localparam int COL_LIM = (SPRITE_WIDTH < cct_pkg::PAT_W) ? SPRITE_WIDTH : cct_pkg::PAT_W;
  localparam int ROW_LIM = (SPRITE_HEIGHT < cct_pkg::PAT_H) ? SPRITE_HEIGHT : cct_pkg::PAT_H;
  localparam int CW = cct_pkg::COORD_W;
  localparam int SW = cct_pkg::STEP_W;

  logic [CW-1:0]        pos_x;
  logic [CW-1:0]        pos_y;
  logic                 shape_sel;
  logic [CW-1:0]        pos_x_next;
  logic [CW-1:0]        pos_y_next;
  logic                 shape_sel_next;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic                 in_x;
  logic                 in_start;
  logic                 in_list;
  logic                 in_quit;
  cct_pkg::region_t     region;
  logic [CW:0]          di;
  logic [CW:0]          dj;
  logic                 in_sprite;
  cct_pkg::cell_t       pat_mark;

  function automatic logic [CW-1:0] clamp(input logic signed [SW-1:0] v,
                                          input logic signed [SW-1:0] hi);
    if (hi < 0 || v < 0) begin
      return '0;
    end else if (v > hi) begin
      return hi[CW-1:0];
    end else begin
      return v[CW-1:0];
    end
  endfunction

  assign cmd_rd = !cmd_empty && !res_full;
  assign res_wr = cmd_rd;

  // motion
  assign sum_x = $signed({{(SW - CW){1'b0}}, pos_x}) + cmd.step_x;
  assign sum_y = $signed({{(SW - CW){1'b0}}, pos_y}) + cmd.step_y;

  always_comb begin
    if (cmd.kind == cct_pkg::CMD_MOVE) begin
      pos_x_next = clamp(sum_x, lim.x_hi);
      pos_y_next = clamp(sum_y, lim.y_hi);
    end else begin
      pos_x_next = pos_x;
      pos_y_next = pos_y;
    end
  end

  assign in_x = (pos_x_next > lim.x_left) && (pos_x_next < lim.x_right);
  assign in_start = in_x && (pos_y_next > lim.start_top) && ({1'b0, pos_y_next} < lim.start_bot);
  assign in_list = in_x && (pos_y_next > lim.list_top) && ({1'b0, pos_y_next} < lim.list_bot);
  assign in_quit = in_x && (pos_y_next > lim.quit_top) && ({1'b0, pos_y_next} < lim.quit_bot);

  always_comb begin
    if (cmd.kind != cct_pkg::CMD_MOVE) begin
      region = cct_pkg::REGION_NONE;
    end else if (in_start) begin
      region = cct_pkg::REGION_START;
    end else if (in_list) begin
      region = cct_pkg::REGION_LIST;
    end else if (in_quit) begin
      region = cct_pkg::REGION_QUIT;
    end else begin
      region = cct_pkg::REGION_NONE;
    end
  end

  assign shape_sel_next = (cmd.kind == cct_pkg::CMD_MOVE) ?
                          (region != cct_pkg::REGION_NONE) : shape_sel;

  // pixel composite against the kept shape
  assign di = {1'b0, cmd.pix_x} - {1'b0, pos_x};
  assign dj = {1'b0, cmd.pix_y} - {1'b0, pos_y};
  assign in_sprite = !di[CW] && !dj[CW] &&
                     (di[CW-1:0] < CW'(COL_LIM)) && (dj[CW-1:0] < CW'(ROW_LIM));
  assign pat_mark = cct_pkg::sprite_cell(shape_sel, dj[4:0], di[3:0]);

  always_comb begin
    res.cursor_x = pos_x_next;
    res.cursor_y = pos_y_next;
    res.region = region;
    res.hover_shape = shape_sel_next;
    res.click = (region != cct_pkg::REGION_NONE) && cmd.left_only;
    res.pixel_out = '0;
    if (cmd.kind == cct_pkg::CMD_PIXEL) begin
      res.pixel_out = cmd.background;
      if (in_sprite) begin
        case (pat_mark)
          cct_pkg::CELL_BORDER: res.pixel_out = cct_pkg::COL_BORDER;
          cct_pkg::CELL_FILL:   res.pixel_out = cct_pkg::COL_FILL;
          default:              res.pixel_out = cmd.background;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= cct_pkg::POS_X_RST;
      pos_y <= cct_pkg::POS_Y_RST;
      shape_sel <= 1'b0;
    end else if (cmd_rd) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      shape_sel <= shape_sel_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/cursor_tracker_compositor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_tracker_compositor
// hardware mouse cursor: motion tracking, region hit test, sprite overlay
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  item      push / full             item_t   (op, dx, dy_raw, button, pix, bg)
//  result    pop / empty             result_t (cursor, region, shape, click, pixel)
//  config    cfg_valid / cfg_ready   cfg_index (3b), cfg_data (12b)
//
//  one item per clock sustained while the request queue has room; a result
//  reaches the result ports through the input stage register and the request
//  queue, then the execution stage writes the result queue in the same cycle
//  that it reads the request; the execution stage moves the cursor and
//  picks the sprite as it reads a request, so the next request sees it at once
//  synchronous reset restores the default registers, centres the cursor
//  and shows the arrow; full rises only once the request queue backs up
//  when result reads stall, the result queue fills, then the request
//  queue, then full rises; nothing is dropped
// ----------------------------------------------------------------------------
module cursor_tracker_compositor #(
  parameter int SPRITE_WIDTH = cct_pkg::SPRITE_WIDTH_DEF,
  parameter int SPRITE_HEIGHT = cct_pkg::SPRITE_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // items
  input  wire logic                        push,
  input  wire cct_pkg::item_t              item,
  output logic                             full,
  // results
  output logic                             empty,
  input  wire logic                        pop,
  output cct_pkg::result_t                 result,
  // configuration
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [cct_pkg::COORD_W-1:0] cfg_data
);

  localparam int CW = cct_pkg::COORD_W;
  localparam int SW = cct_pkg::STEP_W;

  // configuration registers
  logic [CW-1:0] screen_width;
  logic [CW-1:0] screen_height;
  logic [CW-1:0] hit_x_left;
  logic [CW-1:0] hit_x_right;
  logic [CW-1:0] start_y_top;
  logic [CW-1:0] list_y_top;
  logic [CW-1:0] quit_y_top;
  logic [CW-1:0] region_height;

  cct_pkg::lim_t    lim;
  cct_pkg::lim_t    lim_next;

  // front to back request queue
  logic             cmd_wr;
  cct_pkg::cmd_t    cmd_in;
  logic             cmd_full;
  logic             cmd_rd;
  logic [$bits(cct_pkg::cmd_t)-1:0] cmd_bits;
  logic             cmd_empty;

  // back to result queue
  logic             res_wr;
  cct_pkg::result_t res_in;
  logic             res_full;
  logic [$bits(cct_pkg::result_t)-1:0] res_bits;

  // the port never stalls a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 12'd1024;
      screen_height <= 12'd768;
      hit_x_left <= 12'd200;
      hit_x_right <= 12'd300;
      start_y_top <= 12'd200;
      list_y_top <= 12'd350;
      quit_y_top <= 12'd500;
      region_height <= 12'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cct_pkg::cfg_idx_t'(cfg_index))
        cct_pkg::CFG_SCREEN_WIDTH:  screen_width <= cfg_data;
        cct_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        cct_pkg::CFG_HIT_X_LEFT:    hit_x_left <= cfg_data;
        cct_pkg::CFG_HIT_X_RIGHT:   hit_x_right <= cfg_data;
        cct_pkg::CFG_START_Y_TOP:   start_y_top <= cfg_data;
        cct_pkg::CFG_LIST_Y_TOP:    list_y_top <= cfg_data;
        cct_pkg::CFG_QUIT_Y_TOP:    quit_y_top <= cfg_data;
        cct_pkg::CFG_REGION_HEIGHT: region_height <= cfg_data;
        default:                    screen_width <= screen_width;
      endcase
    end
  end

  // derived limits, registered so the execution stage sees only compares;
  // requests first pass the input stage and request queue, so they are settled
  always_comb begin
    lim_next.x_hi = $signed({{(SW - CW){1'b0}}, screen_width}) - SW'(SPRITE_WIDTH) - SW'(1);
    lim_next.y_hi = $signed({{(SW - CW){1'b0}}, screen_height}) - SW'(SPRITE_HEIGHT) - SW'(1);
    lim_next.x_left = hit_x_left;
    lim_next.x_right = hit_x_right;
    // bottoms are one bit wider so they never wrap
    lim_next.start_top = start_y_top;
    lim_next.start_bot = {1'b0, start_y_top} + {1'b0, region_height};
    lim_next.list_top = list_y_top;
    lim_next.list_bot = {1'b0, list_y_top} + {1'b0, region_height};
    lim_next.quit_top = quit_y_top;
    lim_next.quit_bot = {1'b0, quit_y_top} + {1'b0, region_height};
  end

  always_ff @(posedge clk) begin
    lim <= lim_next;
  end

  // front: takes items, classifies them into requests
  cct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  // short queue so front and back stall independently
  cct_fifo #(
    .WIDTH ($bits(cct_pkg::cmd_t)),
    .DEPTH (cct_pkg::MID_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_bits),
    .empty   (cmd_empty)
  );

  // back: cursor state, hit test, overlay
  cct_back #(
    .SPRITE_WIDTH  (SPRITE_WIDTH),
    .SPRITE_HEIGHT (SPRITE_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .cmd       (cct_pkg::cmd_t'(cmd_bits)),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .res_wr    (res_wr),
    .res       (res_in),
    .res_full  (res_full)
  );

  // result queue parts execution from the reader
  cct_fifo #(
    .WIDTH ($bits(cct_pkg::result_t)),
    .DEPTH (cct_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign result = cct_pkg::result_t'(res_bits);

endmodule
`default_nettype wire
